FILE: rtl/tlss_pkg.sv
// Package for the two-level spill/fill stack: sizes, request codes and
// the beat types of the input and result channels.
// No dependencies.
package tlss_pkg;

  // Store sizes
  localparam int LOCAL_DEPTH = 256;
  localparam int SPILL_DEPTH = 4096;
  localparam int REF_BITS    = 48;

  // Derived widths
  localparam int LAW = $clog2(LOCAL_DEPTH);      // local RAM address
  localparam int SAW = $clog2(SPILL_DEPTH);      // spill RAM address
  localparam int LCW = $clog2(LOCAL_DEPTH + 1);  // local count
  localparam int SCW = $clog2(SPILL_DEPTH + 1);  // spill count
  localparam int PW  = (SAW > LAW) ? SAW : LAW;  // copy pointer

  // Fixed field widths of the channels
  localparam int REQ_W        = 2;
  localparam int OBJ_W        = 48;
  localparam int LOCAL_FILL_W = 9;
  localparam int PEAK_FILL_W  = 9;
  localparam int SPILL_FILL_W = 13;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CYCLE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [OBJ_W-1:0] object_ref;
  } in_t;

  typedef struct packed {
    logic [OBJ_W-1:0]        pop_value;
    logic                    pop_valid;
    logic                    all_empty;
    logic [LOCAL_FILL_W-1:0] local_fill;
    logic [PEAK_FILL_W-1:0]  peak_fill;
    logic [SPILL_FILL_W-1:0] spill_fill;
    logic                    spill_refused;
  } out_t;

endpackage

FILE: rtl/two_level_spill_fill_stack.sv
// Top level of the two-level spill/fill stack.
// Depends on tlss_pkg and tlss_ram.
//
// A LIFO of object references: a local stack RAM backed by a larger spill
// stack RAM. Input beats (in_valid_i / in_stall_o / in_data_i) carry a
// push, a pop or a marking-cycle reset; each accepted beat gives exactly one
// result beat on out_valid_o / out_stall_i / out_data_o.
// Path from the accepted beat to the result register:
//   push with room, null push, refused push, empty pop, cycle reset: straight from the request
//   pop from a non-empty local stack: one registered RAM read (S_POP)
//   push into a full local stack: spill copy of LOCAL_DEPTH entries (S_SPILL)
//   pop from an empty local stack: fill copy of min(spill, LOCAL_DEPTH) entries (S_FILL)
// The copies move one entry per cycle through the single read port of
// one RAM and the write port of the other, driven by one copy counter.
// One beat is in work at a time, so requests with no RAM read or copy run at a
// beat per cycle; the next is taken once the result register is free or drained.
// Reset clears the counts, the peak and the handshake state; the RAM
// contents are not cleared and need no sweep. A stalled result stays
// in the output register unchanged, and input is stalled meanwhile.
module two_level_spill_fill_stack
  import tlss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_POP   = 2'd1;
  localparam logic [1:0] S_SPILL = 2'd2;
  localparam logic [1:0] S_FILL  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [LCW-1:0]      cnt_q, cnt_d;
  logic [LCW-1:0]      len_q, len_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [REF_BITS-1:0] obj_q, obj_d;
  logic [LCW-1:0]      lcount_q, lcount_d;
  logic [LCW-1:0]      peak_q, peak_d;
  logic [SCW-1:0]      scount_q, scount_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  // RAM ports
  logic                l_we, l_re, s_we, s_re;
  logic [LAW-1:0]      l_waddr, l_raddr;
  logic [SAW-1:0]      s_waddr, s_raddr;
  logic [REF_BITS-1:0] l_wdata, l_rdata, s_wdata, s_rdata;

  logic                out_free, accept;
  logic [REF_BITS-1:0] obj_in;
  logic [LCW-1:0]      take;
  logic [SCW-1:0]      base;
  logic                no_room;

  function automatic out_t make_res(logic [REF_BITS-1:0] val, logic vld,
                                    logic [LCW-1:0] lc, logic [LCW-1:0] pk,
                                    logic [SCW-1:0] sc, logic refused);
    out_t r;
    r.pop_value     = OBJ_W'(val);
    r.pop_valid     = vld;
    r.all_empty     = (lc == '0) && (sc == '0);
    r.local_fill    = LOCAL_FILL_W'(lc);
    r.peak_fill     = PEAK_FILL_W'(pk);
    r.spill_fill    = SPILL_FILL_W'(sc);
    r.spill_refused = refused;
    return r;
  endfunction

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign obj_in     = REF_BITS'(in_data_i.object_ref);

  // Spill room check and refill size
  assign no_room = ({1'b0, scount_q} + (SCW+1)'(LOCAL_DEPTH)) > (SCW+1)'(SPILL_DEPTH);
  assign take    = (scount_q < SCW'(LOCAL_DEPTH)) ? LCW'(scount_q) : LCW'(LOCAL_DEPTH);
  assign base    = scount_q - SCW'(take);

  // Sequencer and copy engine
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    obj_d       = obj_q;
    lcount_d    = lcount_q;
    peak_d      = peak_q;
    scount_d    = scount_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            REQ_PUSH: begin
              if (obj_in == '0) begin
                out_valid_d = 1'b1;
                out_d = make_res('0, 1'b0, lcount_q, peak_q, scount_q, 1'b0);
              end else if (lcount_q < LCW'(LOCAL_DEPTH)) begin
                l_we     = 1'b1;
                l_waddr  = LAW'(lcount_q);
                l_wdata  = obj_in;
                lcount_d = lcount_q + LCW'(1);
                peak_d   = (lcount_d > peak_q) ? lcount_d : peak_q;
                out_valid_d = 1'b1;
                out_d = make_res('0, 1'b0, lcount_d, peak_d, scount_q, 1'b0);
              end else if (no_room) begin
                peak_d = LCW'(LOCAL_DEPTH);
                out_valid_d = 1'b1;
                out_d = make_res('0, 1'b0, lcount_q, peak_d, scount_q, 1'b1);
              end else begin
                obj_d    = obj_in;
                cnt_d    = '0;
                len_d    = LCW'(LOCAL_DEPTH);
                rd_ptr_d = '0;
                wr_ptr_d = PW'(scount_q);
                state_d  = S_SPILL;
              end
            end
            REQ_POP: begin
              if (lcount_q != '0) begin
                l_re     = 1'b1;
                l_raddr  = LAW'(lcount_q - LCW'(1));
                lcount_d = lcount_q - LCW'(1);
                state_d  = S_POP;
              end else if (scount_q != '0) begin
                cnt_d    = '0;
                len_d    = take;
                rd_ptr_d = PW'(base);
                wr_ptr_d = '0;
                scount_d = base;
                state_d  = S_FILL;
              end else begin
                out_valid_d = 1'b1;
                out_d = make_res('0, 1'b0, lcount_q, peak_q, scount_q, 1'b0);
              end
            end
            REQ_CYCLE: begin
              lcount_d = '0;
              peak_d   = '0;
              out_valid_d = 1'b1;
              out_d = make_res('0, 1'b0, '0, '0, scount_q, 1'b0);
            end
            default: begin
              out_valid_d = 1'b1;
              out_d = make_res('0, 1'b0, lcount_q, peak_q, scount_q, 1'b0);
            end
          endcase
        end
      end

      // Local top arrives from the registered read
      S_POP: begin
        out_valid_d = 1'b1;
        out_d   = make_res(l_rdata, 1'b1, lcount_q, peak_q, scount_q, 1'b0);
        state_d = S_IDLE;
      end

      // Local stack to spill tail, one entry a cycle, then store the push
      S_SPILL: begin
        cnt_d = cnt_q + LCW'(1);
        if (cnt_q < len_q) begin
          l_re     = 1'b1;
          l_raddr  = LAW'(rd_ptr_q);
          rd_ptr_d = rd_ptr_q + PW'(1);
        end
        if (cnt_q != '0) begin
          s_we     = 1'b1;
          s_waddr  = SAW'(wr_ptr_q);
          s_wdata  = l_rdata;
          wr_ptr_d = wr_ptr_q + PW'(1);
        end
        if (cnt_q == len_q) begin
          l_we     = 1'b1;
          l_waddr  = '0;
          l_wdata  = obj_q;
          lcount_d = LCW'(1);
          scount_d = scount_q + SCW'(LOCAL_DEPTH);
          peak_d   = LCW'(LOCAL_DEPTH);
          out_valid_d = 1'b1;
          out_d   = make_res('0, 1'b0, lcount_d, peak_d, scount_d, 1'b0);
          state_d = S_IDLE;
        end
      end

      // Spill tail to local stack; the last entry moved is the popped one
      S_FILL: begin
        cnt_d = cnt_q + LCW'(1);
        if (cnt_q < len_q) begin
          s_re     = 1'b1;
          s_raddr  = SAW'(rd_ptr_q);
          rd_ptr_d = rd_ptr_q + PW'(1);
        end
        if (cnt_q != '0) begin
          l_we     = 1'b1;
          l_waddr  = LAW'(wr_ptr_q);
          l_wdata  = s_rdata;
          wr_ptr_d = wr_ptr_q + PW'(1);
        end
        if (cnt_q == len_q) begin
          lcount_d = len_q - LCW'(1);
          out_valid_d = 1'b1;
          out_d   = make_res(s_rdata, 1'b1, lcount_d, peak_q, scount_q, 1'b0);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcount_q    <= '0;
      peak_q      <= '0;
      scount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcount_q    <= lcount_d;
      peak_q      <= peak_d;
      scount_q    <= scount_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and copy registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    len_q    <= len_d;
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    obj_q    <= obj_d;
    out_q    <= out_d;
  end

  // Local stack store
  tlss_ram #(
    .WIDTH(REF_BITS),
    .DEPTH(LOCAL_DEPTH)
  ) u_local_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  // Spill stack store
  tlss_ram #(
    .WIDTH(REF_BITS),
    .DEPTH(SPILL_DEPTH)
  ) u_spill_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(s_wdata),
    .re_i   (s_re),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/tlss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlss_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
